[hw/rtl/mm3_pkg.sv]
// shared types, constants and helpers for the murmur3 x86_32 stream hash
package mm3_pkg;

    localparam int unsigned CNT_W = 4;
    localparam int unsigned LEN_W = 32;

    localparam logic [31:0] C1      = 32'hcc9e2d51;
    localparam logic [31:0] C2      = 32'h1b873593;
    localparam logic [31:0] C3      = 32'h85ebca6b;
    localparam logic [31:0] C4      = 32'hc2b2ae35;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;

    localparam int unsigned ROT_SCR = 15;
    localparam int unsigned ROT_MIX = 13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCR,
        S_MIX,
        S_FIN_A,
        S_FIN_B,
        S_FIN_C
    } t_state;

    typedef struct packed {
        logic ld;
        logic run;
    } t_lane_ctrl;

    typedef struct packed {
        logic start;
        logic mix;
        logic fin_a;
        logic fin_b;
        logic tail;
    } t_mix_ctrl;

    function automatic logic [31:0] f_rotl(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

[hw/rtl/mm3_lane.sv]
// one block scramble lane: multiply, rotate, multiply over two register stages
module mm3_lane
    import mm3_pkg::*;
(
    input  logic        i_clk,
    input  t_lane_ctrl  i_ctrl,
    input  logic [31:0] i_word,
    output logic [31:0] o_scr
);

    logic [31:0] r_m1;
    logic [31:0] r_scr;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld) begin
            r_m1 <= i_word * C1;
        end
        if (i_ctrl.run) begin
            r_scr <= f_rotl(r_m1, ROT_SCR) * C2;
        end
    end

    assign o_scr = r_scr;

endmodule

[hw/rtl/mm3_mix.sv]
// merge stage: running hash accumulator, body mix, tail and fmix32 finalization
module mm3_mix
    import mm3_pkg::*;
(
    input  logic             i_clk,
    input  t_mix_ctrl        i_ctrl,
    input  logic [31:0]      i_seed,
    input  logic [31:0]      i_scr,
    input  logic [LEN_W-1:0] i_len,
    output logic [31:0]      o_hash
);

    logic [31:0] r_acc;
    logic [31:0] r_fin;
    logic [31:0] acc_rot;
    logic [31:0] acc_next;
    logic [31:0] h_pre;
    logic [31:0] h_sh;
    logic [31:0] f_sh;

    always_comb begin
        acc_rot  = f_rotl(r_acc ^ i_scr, ROT_MIX);
        // times five as shift plus add
        acc_next = (acc_rot << 2) + acc_rot + MIX_ADD;
        h_pre    = r_acc ^ (i_ctrl.tail ? i_scr : 32'h0) ^ i_len;
        h_sh     = h_pre ^ (h_pre >> 16);
        f_sh     = r_fin ^ (r_fin >> 13);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_acc <= i_seed;
        end else if (i_ctrl.mix) begin
            r_acc <= acc_next;
        end
        if (i_ctrl.fin_a) begin
            r_fin <= h_sh * C3;
        end else if (i_ctrl.fin_b) begin
            r_fin <= f_sh * C4;
        end
    end

    assign o_hash = r_fin ^ (r_fin >> 16);

endmodule

[hw/rtl/murmur3_x86_32_stream_hash.sv]
// top level: byte packing, lane array, sequencer and result register
//
// Streaming MurmurHash3 x86_32. A request on the input channel (i_valid,
// o_stall) carries up to CHUNK_BYTES message bytes, first byte in bits 7:0,
// a byte count and a last flag. Bytes join up to three pending bytes from
// earlier requests; every full 32-bit block is scrambled in its own lane
// and the lanes' results are folded into the running hash one block per
// cycle. A request passes S_IDLE and S_SCR, then S_MIX once per full
// block it completes (0 to 2 with eight-byte chunks); o_stall stays high
// meanwhile, so the next request is taken only back in S_IDLE. A request
// with last set then runs the tail and fmix32 states S_FIN_A, S_FIN_B and
// S_FIN_C before the hash lands in the result register. The seed is written
// through the configuration channel (i_cfg_valid, o_cfg_ready, always
// ready) and is loaded when a message starts. Reset clears the seed to
// zero and leaves the block idle with no message open. While the receiver
// stalls, the hash waits in the result register and the block keeps taking
// requests; only a new finalization waits until the register is free.
module murmur3_x86_32_stream_hash
    import mm3_pkg::*;
#(
    parameter int unsigned CHUNK_BYTES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [63:0]      i_data_bytes,
    input  logic [CNT_W-1:0] i_byte_count,
    input  logic             i_last,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [31:0]      o_hash
);

    // one lane per full block plus one for the tail word
    localparam int unsigned NW     = (CHUNK_BYTES + 3) / 4 + 1;
    localparam int unsigned BW     = 32 * NW;
    localparam int unsigned NBLK_W = $clog2(NW);
    localparam int unsigned DW     = 8 * CHUNK_BYTES;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CHUNK_BYTES);

    t_state r_state;
    t_state n_state;

    logic [31:0]       r_seed;
    logic              r_in_msg;
    logic [1:0]        r_pc;
    logic [23:0]       r_pend;
    logic [LEN_W-1:0]  r_len;
    logic [NBLK_W-1:0] r_nblk;
    logic [NBLK_W-1:0] r_idx;
    logic              r_last;
    logic              r_tail_en;
    logic              r_out_valid;
    logic [31:0]       r_out;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [CNT_W-1:0]  cnt;
    logic [1:0]        pc_eff;
    logic [DW-1:0]     data_m;
    logic [23:0]       pend_m;
    logic [BW-1:0]     comb_bytes;
    logic [BW-1:0]     rest_bytes;
    logic [4:0]        n_bytes;
    logic [NBLK_W-1:0] nblk;
    logic [LEN_W-1:0]  len_new;
    logic [31:0]       hash_fin;
    logic [31:0]       w_scr [NW];

    t_lane_ctrl lane_ctrl;
    t_mix_ctrl  mix_ctrl;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;

    // byte packing: pending bytes first, then the new bytes
    always_comb begin
        cnt    = (i_byte_count > CNT_MAX) ? CNT_MAX : i_byte_count;
        pc_eff = r_in_msg ? r_pc : 2'd0;
        for (int b = 0; b < CHUNK_BYTES; b++) begin
            data_m[8*b +: 8] = (CNT_W'(b) < cnt) ? i_data_bytes[8*b +: 8] : 8'h00;
        end
        for (int b = 0; b < 3; b++) begin
            pend_m[8*b +: 8] = (2'(b) < pc_eff) ? r_pend[8*b +: 8] : 8'h00;
        end
        comb_bytes = (BW'(data_m) << {pc_eff, 3'b000}) | BW'(pend_m);
        n_bytes    = {3'b000, pc_eff} + {1'b0, cnt};
        nblk       = n_bytes[2 +: NBLK_W];
        rest_bytes = comb_bytes >> {nblk, 5'b00000};
        len_new    = (r_in_msg ? r_len : '0) + LEN_W'(cnt);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCR;
                end
            end
            S_SCR: begin
                if (r_nblk == '0) begin
                    n_state = r_last ? S_FIN_A : S_IDLE;
                end else begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                if (r_idx + 1'b1 == r_nblk) begin
                    n_state = r_last ? S_FIN_A : S_IDLE;
                end
            end
            S_FIN_A: n_state = S_FIN_B;
            S_FIN_B: n_state = S_FIN_C;
            S_FIN_C: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall        = 1'b1;
        lane_ctrl.ld   = 1'b0;
        lane_ctrl.run  = 1'b0;
        mix_ctrl.start = 1'b0;
        mix_ctrl.mix   = 1'b0;
        mix_ctrl.fin_a = 1'b0;
        mix_ctrl.fin_b = 1'b0;
        mix_ctrl.tail  = r_tail_en;
        out_load       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall        = 1'b0;
                lane_ctrl.ld   = i_valid;
                mix_ctrl.start = i_valid && !r_in_msg;
            end
            S_SCR:   lane_ctrl.run  = 1'b1;
            S_MIX:   mix_ctrl.mix   = 1'b1;
            S_FIN_A: mix_ctrl.fin_a = 1'b1;
            S_FIN_B: mix_ctrl.fin_b = 1'b1;
            S_FIN_C: out_load       = out_free;
            default: o_stall        = 1'b1;
        endcase
    end

    for (genvar k = 0; k < NW; k++) begin : g_lane
        mm3_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (lane_ctrl),
            .i_word (comb_bytes[32*k +: 32]),
            .o_scr  (w_scr[k])
        );
    end

    mm3_mix u_mix (
        .i_clk  (i_clk),
        .i_ctrl (mix_ctrl),
        .i_seed (r_seed),
        .i_scr  (w_scr[r_idx]),
        .i_len  (r_len),
        .o_hash (hash_fin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= 32'h0;
            r_in_msg    <= 1'b0;
            r_pc        <= 2'd0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (accept) begin
                r_in_msg <= !i_last;
                r_pc     <= n_bytes[1:0];
                r_idx    <= '0;
            end else if (r_state == S_MIX) begin
                r_idx <= r_idx + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend    <= rest_bytes[23:0];
            r_len     <= len_new;
            r_nblk    <= nblk;
            r_last    <= i_last;
            r_tail_en <= i_last && (n_bytes[1:0] != 2'd0);
        end
        if (out_load) begin
            r_out <= hash_fin;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hash  = r_out;

    // the block index never runs past the blocks of the current request
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |-> (r_idx < r_nblk))
        else $error("block index beyond block count");

    // length grows by the clamped byte count within a message
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_in_msg) |=> (r_len == $past(r_len) + LEN_W'($past(cnt))))
        else $error("length not advanced by byte count");

    // a finished hash always shows up on the output
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid)
        else $error("loaded hash not presented");

    // finalization only follows a request that closed its message
    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN_A) |-> (r_last && !r_in_msg))
        else $error("finalization without last request");

endmodule
